>>> hdl/mpp_pkg.sv
// Shared constants and control types for the minimum palindrome partition block.
// Used by the controller, the datapath, the top level and the port checker.
// Depends on nothing.
package mpp_pkg;

  // Capacity of one string in bytes.
  localparam int unsigned MAX_LEN   = 1024;
  // Index of a stored byte.
  localparam int unsigned ADDR_W    = $clog2(MAX_LEN);
  // Length of a string, which can reach MAX_LEN itself.
  localparam int unsigned LEN_W     = $clog2(MAX_LEN + 1);
  // Prefix count table holds one entry per prefix length, empty prefix included.
  localparam int unsigned CNT_DEPTH = MAX_LEN + 1;

  // Field widths on the stream ports.
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned START_W   = 10;
  localparam int unsigned M_TDATA_W = 24;
  localparam int unsigned M_PAD_W   = M_TDATA_W - COUNT_W - START_W;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;  // input transfer taken: latch the byte and set up the sweep
    logic issue;  // read the stores at the current start position
    logic load;   // move the result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ovf_next;    // the byte being taken does not fit in the string
    logic sweep_done;  // the current start position is the newest byte
  } dp_status_t;

endpackage

>>> hdl/mpp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the text, palindrome bit and prefix count stores. No dependencies.
module mpp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read; a read of the written address returns old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/mpp_ctrl.sv
// Controller of the minimum palindrome partition block: sequences the sweep over
// start positions and owns both stream handshakes. Depends on mpp_pkg.
module mpp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  mpp_pkg::dp_status_t status_i,
  output mpp_pkg::ctrl_cmd_t  cmd_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StSweep = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;
  localparam logic [1:0] StOut   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       load;

  assign in_ready_o = (state_q == StIdle);
  assign load       = (state_q == StOut) && (!out_valid_q || out_ready_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = status_i.ovf_next ? StOut : StSweep;
        end
      end
      StSweep: begin
        if (status_i.sweep_done) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StOut;
      end
      StOut: begin
        if (load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // The output register holds a result until its transfer completes.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o.start = in_valid_i && (state_q == StIdle);
  assign cmd_o.issue = (state_q == StSweep);
  assign cmd_o.load  = load;

endmodule

>>> hdl/mpp_datapath.sv
// Datapath of the minimum palindrome partition block: the three stores, the
// sweep counter, the compare stage, the running minimum and the result register.
// Depends on mpp_pkg and mpp_ram.
module mpp_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [mpp_pkg::CHAR_W-1:0]     char_in_i,
  input  logic                           last_char_i,
  input  mpp_pkg::ctrl_cmd_t             cmd_i,
  output mpp_pkg::dp_status_t            status_o,
  output logic [mpp_pkg::COUNT_W-1:0]    piece_count_o,
  output logic [mpp_pkg::START_W-1:0]    piece_start_o,
  output logic                           overflow_o
);

  localparam int unsigned AW = mpp_pkg::ADDR_W;
  localparam int unsigned LW = mpp_pkg::LEN_W;
  localparam int unsigned CW = mpp_pkg::COUNT_W;
  localparam int unsigned SW = mpp_pkg::START_W;

  // String state.
  logic [LW-1:0]                 len_q;
  logic                          ovf_q;
  logic                          ovf_next;
  logic [mpp_pkg::CHAR_W-1:0]    char_q;
  logic                          last_q;

  // Sweep issue counter and compare stage.
  logic [AW-1:0] j_q;
  logic [AW-1:0] j2_q;
  logic          v2_q;

  // Running minimum.
  logic [LW-1:0] best_q, best_d;
  logic [AW-1:0] best_start_q, best_start_d;

  // Result register.
  logic [CW-1:0] out_count_q;
  logic [SW-1:0] out_start_q;
  logic          out_ovf_q;

  // Store read data.
  logic [mpp_pkg::CHAR_W-1:0] text_rd;
  logic                       pal_rd;
  logic [LW-1:0]              cnt_rd;

  // Compare stage signals.
  logic          new_pal;
  logic          at_newest;
  logic          inner_short;
  logic [LW-1:0] cnt_prev;
  logic [LW-1:0] cand;
  logic [LW-1:0] cnt_waddr;

  // Widening helpers for the result fields.
  logic [LW+CW-1:0] count_ext;
  logic [AW+SW-1:0] start_ext;

  // A byte does not fit once the string already holds MAX_LEN bytes.
  assign ovf_next = ovf_q || (len_q == LW'(mpp_pkg::MAX_LEN));

  assign status_o.ovf_next   = ovf_next;
  assign status_o.sweep_done = (LW'(j_q) == len_q);

  // Stores: text by position, palindrome bit per start, fewest pieces per prefix.
  mpp_ram #(
    .WIDTH (mpp_pkg::CHAR_W),
    .DEPTH (mpp_pkg::MAX_LEN)
  ) u_text (
    .clk_i   (clk_i),
    .we_i    (cmd_i.start && !ovf_next),
    .waddr_i (len_q[AW-1:0]),
    .wdata_i (char_in_i),
    .raddr_i (j_q),
    .rdata_o (text_rd)
  );

  mpp_ram #(
    .WIDTH (1),
    .DEPTH (mpp_pkg::MAX_LEN)
  ) u_pal (
    .clk_i   (clk_i),
    .we_i    (v2_q),
    .waddr_i (j2_q),
    .wdata_i (new_pal),
    .raddr_i (j_q + AW'(1)),
    .rdata_o (pal_rd)
  );

  assign cnt_waddr = len_q + LW'(1);

  mpp_ram #(
    .WIDTH (LW),
    .DEPTH (mpp_pkg::CNT_DEPTH)
  ) u_cnt (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && !ovf_q),
    .waddr_i (cnt_waddr),
    .wdata_i (best_q),
    .raddr_i (LW'(j_q)),
    .rdata_o (cnt_rd)
  );

  // Compare stage: text[j..k] is a palindrome when its ends match and its inside
  // is one; the newest byte alone always is. The empty prefix needs no pieces.
  assign at_newest   = (LW'(j2_q) == len_q);
  assign inner_short = ((LW'(j2_q) + LW'(1)) == len_q);
  assign new_pal     = at_newest || ((text_rd == char_q) && (inner_short || pal_rd));
  assign cnt_prev    = (j2_q == '0) ? '0 : cnt_rd;
  assign cand        = cnt_prev + LW'(1);

  // Minimum over the palindromic suffixes; a later start wins a tie.
  always_comb begin
    best_d       = best_q;
    best_start_d = best_start_q;
    if (cmd_i.start) begin
      best_d       = '1;
      best_start_d = '0;
    end else if (v2_q && new_pal && (cand <= best_q)) begin
      best_d       = cand;
      best_start_d = j2_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    best_q       <= best_d;
    best_start_q <= best_start_d;
    j2_q         <= j_q;
    if (cmd_i.start) begin
      char_q <= char_in_i;
      last_q <= last_char_i;
      j_q    <= '0;
    end else if (cmd_i.issue) begin
      j_q <= j_q + AW'(1);
    end
  end

  assign count_ext = {{CW{1'b0}}, best_q};
  assign start_ext = {{SW{1'b0}}, best_start_q};

  // Result register; an overflowed string reports zero fields.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_ovf_q <= ovf_q;
      if (ovf_q) begin
        out_count_q <= '0;
        out_start_q <= '0;
      end else begin
        out_count_q <= count_ext[CW-1:0];
        out_start_q <= start_ext[SW-1:0];
      end
    end
  end

  // String length, overflow flag and compare stage valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      ovf_q <= 1'b0;
      v2_q  <= 1'b0;
    end else begin
      v2_q <= cmd_i.issue;
      if (cmd_i.start) begin
        ovf_q <= ovf_next;
      end else if (cmd_i.load) begin
        if (last_q) begin
          len_q <= '0;
          ovf_q <= 1'b0;
        end else if (!ovf_q) begin
          len_q <= len_q + LW'(1);
        end
      end
    end
  end

  assign piece_count_o = out_count_q;
  assign piece_start_o = out_start_q;
  assign overflow_o    = out_ovf_q;

endmodule

>>> hdl/min_palindrome_partition_core.sv
// Top level of the minimum palindrome partition block.
// Joins mpp_ctrl and mpp_datapath; depends on mpp_pkg.
//
// Usage:
// Bytes of a string arrive on the slave stream, one per transfer, with tlast
// on the final byte; the next transfer then begins a new string. For every
// byte one result leaves on the master stream: the fewest palindromic pieces
// that cover the prefix ending at that byte and the start index of the last
// piece, so the host can rebuild the split by following the starts backwards.
// A string holds up to 1024 bytes; further bytes are dropped and their results
// carry tuser (overflow) set with zero data until the string ends.
// Timing: after the transfer of the byte at index k the block sweeps all k + 1
// start positions, one store read per cycle through the compare and minimum
// stage, drains that stage and loads the result register; the result is valid
// and the slave side is ready again in that same cycle. Overflowed bytes skip
// the sweep. The block works on one byte at a time.
// A finished result waits in the output register while the next byte is
// swept; if the receiver still stalls, the block holds its result and waits.
// Reset empties the current string and clears the output valid.
module min_palindrome_partition_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [mpp_pkg::CHAR_W-1:0]      s_axis_tdata,  // [7:0] char_in
  input  logic                            s_axis_tlast,  // last_char
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [mpp_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // [10:0] piece_count,
                                                         // [20:11] piece_start, zero pad
  output logic                            m_axis_tuser   // overflow
);

  mpp_pkg::ctrl_cmd_t           cmd;
  mpp_pkg::dp_status_t          status;
  logic [mpp_pkg::COUNT_W-1:0]  piece_count;
  logic [mpp_pkg::START_W-1:0]  piece_start;

  // Sequencer and handshakes.
  mpp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Stores, sweep and result register.
  mpp_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .char_in_i     (s_axis_tdata),
    .last_char_i   (s_axis_tlast),
    .cmd_i         (cmd),
    .status_o      (status),
    .piece_count_o (piece_count),
    .piece_start_o (piece_start),
    .overflow_o    (m_axis_tuser)
  );

  assign m_axis_tdata = {{mpp_pkg::M_PAD_W{1'b0}}, piece_start, piece_count};

endmodule

>>> hdl/mpp_checker.sv
// Port-level checks for the minimum palindrome partition block, bound to the top.
// Depends on mpp_pkg and min_palindrome_partition_core.
module mpp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [mpp_pkg::CHAR_W-1:0]     s_axis_tdata,
  input logic                           s_axis_tlast,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [mpp_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input logic                           m_axis_tuser
);

  localparam int unsigned CW = mpp_pkg::COUNT_W;
  localparam int unsigned SW = mpp_pkg::START_W;

  logic [CW-1:0] count;
  logic [CW-1:0] start_plus_one;
  logic          in_xfer;

  assign count          = m_axis_tdata[CW-1:0];
  assign start_plus_one = CW'(m_axis_tdata[CW+SW-1:CW]) + CW'(1);
  assign in_xfer        = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata)
                          && (s_axis_tlast == s_axis_tlast);

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // An overflowed result carries no count and no start.
  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("overflow result with nonzero data");

  // A stored byte always needs at least one piece, and never more than its
  // last piece's start plus one.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (count != '0) && (count <= start_plus_one))
    else $error("piece count out of range for its start");

  // The block works on one byte at a time: no input transfer right after one.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready)
    else $error("input taken while a byte is still in work");

endmodule

bind min_palindrome_partition_core mpp_checker u_mpp_checker (.*);
